[src/apcid_pkg.sv]
// shared types and constants for the apci frame deframer
`default_nettype none
package apcid_pkg;

    localparam logic [7:0]  START_BYTE_RESET = 8'h68;
    localparam logic [15:0] APCI_BYTES       = 16'd4;
    localparam logic [7:0]  S_FORMAT_CODE    = 8'h01;

    typedef enum logic [2:0] {
        PH_HUNT   = 3'd0,
        PH_LEN_LO = 3'd1,
        PH_LEN_HI = 3'd2,
        PH_APCI   = 3'd3,
        PH_ASDU   = 3'd4
    } t_phase;

    typedef enum logic [1:0] {
        KIND_HEADER  = 2'd0,
        KIND_PAYLOAD = 2'd1,
        KIND_REJECT  = 2'd2
    } t_kind;

    typedef enum logic [1:0] {
        FMT_I = 2'd0,
        FMT_S = 2'd1,
        FMT_U = 2'd2
    } t_format;

    typedef struct packed {
        t_format     apdu_format;
        logic [14:0] send_seq;
        logic [14:0] recv_seq;
        logic [7:0]  u_control;
        logic        apci_nonzero;
    } t_header;

endpackage
`default_nettype wire

[src/apcid_header_decode.sv]
// decodes the four apci bytes into the header fields
`default_nettype none
module apcid_header_decode
    import apcid_pkg::*;
(
    input  wire logic [7:0] i_byte0,
    input  wire logic [7:0] i_byte1,
    input  wire logic [7:0] i_byte2,
    input  wire logic [7:0] i_byte3,
    output t_header         o_header
);

    t_format fmt;

    always_comb begin
        if (!i_byte0[0]) begin
            fmt = FMT_I;
        end else if (i_byte0 == S_FORMAT_CODE) begin
            fmt = FMT_S;
        end else begin
            fmt = FMT_U;
        end
    end

    always_comb begin
        o_header.apdu_format  = fmt;
        o_header.send_seq     = (fmt == FMT_I) ? {i_byte1, i_byte0[7:1]} : 15'd0;
        o_header.recv_seq     = (fmt != FMT_U) ? {i_byte3, i_byte2[7:1]} : 15'd0;
        o_header.u_control    = i_byte0;
        o_header.apci_nonzero = |{i_byte0, i_byte1, i_byte2, i_byte3};
    end

endmodule
`default_nettype wire

[src/apci_frame_deframer_unit.sv]
// apci frame deframer top level: byte stream in, header and payload words out
//
//  channel   dir  handshake                   payload
//  in        in   i_in_valid / o_in_stall     i_in_byte
//  out       out  o_out_valid / i_out_stall   o_result_kind .. o_last
//  cfg       in   i_cfg_we                    i_cfg_data (start byte)
//
// one input word per cycle while the input is not stalled; each word is decoded in the
// accept cycle and its result, if any, is registered into the output register
// synchronous active-low reset returns to hunting with start byte 68h
// the input stalls only while a result is held and the output is stalled
`default_nettype none
module apci_frame_deframer_unit
    import apcid_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic [7:0]  i_cfg_data,
    input  wire logic        i_in_valid,
    output logic             o_in_stall,
    input  wire logic [7:0]  i_in_byte,
    output logic             o_out_valid,
    input  wire logic        i_out_stall,
    output logic [1:0]       o_result_kind,
    output logic [1:0]       o_apdu_format,
    output logic [14:0]      o_send_seq,
    output logic [14:0]      o_recv_seq,
    output logic [7:0]       o_u_control,
    output logic [15:0]      o_asdu_length,
    output logic             o_apci_nonzero,
    output logic [7:0]       o_payload_byte,
    output logic             o_last
);

    t_phase      r_phase, n_phase;
    logic [7:0]  r_start_byte;
    logic [7:0]  r_len_lo, n_len_lo;
    logic [15:0] r_asdu_len, n_asdu_len;
    logic [15:0] r_count, n_count;
    logic [7:0]  r_apci [3];
    logic        r_out_valid;
    t_kind       r_kind;
    t_header     r_hdr;
    logic [15:0] r_alen_out;
    logic [7:0]  r_pay;
    logic        r_last;

    logic        accept;
    logic        res_valid;
    t_kind       res_kind;
    logic        res_last;
    logic [15:0] full_len;
    logic [15:0] count_inc;
    t_header     hdr;

    assign o_in_stall = r_out_valid && i_out_stall;
    assign accept     = i_in_valid && !o_in_stall;
    assign full_len   = {i_in_byte, r_len_lo};
    assign count_inc  = r_count + 16'd1;

    apcid_header_decode u_hdr (
        .i_byte0  (r_apci[0]),
        .i_byte1  (r_apci[1]),
        .i_byte2  (r_apci[2]),
        .i_byte3  (i_in_byte),
        .o_header (hdr)
    );

    always_comb begin
        n_phase    = r_phase;
        n_len_lo   = r_len_lo;
        n_asdu_len = r_asdu_len;
        n_count    = r_count;
        res_valid  = 1'b0;
        res_kind   = KIND_HEADER;
        res_last   = 1'b0;
        case (r_phase)
            PH_LEN_LO: begin
                n_len_lo = i_in_byte;
                n_phase  = PH_LEN_HI;
            end
            PH_LEN_HI: begin
                if (full_len < APCI_BYTES) begin
                    res_valid = 1'b1;
                    res_kind  = KIND_REJECT;
                    res_last  = 1'b1;
                    n_phase   = PH_HUNT;
                end else begin
                    n_asdu_len = full_len - APCI_BYTES;
                    n_count    = 16'd0;
                    n_phase    = PH_APCI;
                end
            end
            PH_APCI: begin
                n_count = count_inc;
                if (r_count[1:0] == 2'd3) begin
                    res_valid = 1'b1;
                    res_kind  = KIND_HEADER;
                    res_last  = (r_asdu_len == 16'd0);
                    n_count   = 16'd0;
                    n_phase   = (r_asdu_len == 16'd0) ? PH_HUNT : PH_ASDU;
                end
            end
            PH_ASDU: begin
                n_count   = count_inc;
                res_valid = 1'b1;
                res_kind  = KIND_PAYLOAD;
                res_last  = (count_inc >= r_asdu_len);
                if (count_inc >= r_asdu_len) begin
                    n_phase = PH_HUNT;
                end
            end
            default: begin
                n_phase = PH_HUNT;
                if (i_in_byte == r_start_byte) begin
                    n_count = 16'd0;
                    n_phase = PH_LEN_LO;
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= PH_HUNT;
            r_start_byte <= START_BYTE_RESET;
            r_len_lo     <= 8'd0;
            r_asdu_len   <= 16'd0;
            r_count      <= 16'd0;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_start_byte <= i_cfg_data;
            end
            if (accept) begin
                r_phase    <= n_phase;
                r_len_lo   <= n_len_lo;
                r_asdu_len <= n_asdu_len;
                r_count    <= n_count;
            end
            if (accept && res_valid) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept && (r_phase == PH_APCI) && (r_count[1:0] != 2'd3)) begin
            r_apci[r_count[1:0]] <= i_in_byte;
        end
        if (accept && res_valid) begin
            r_kind <= res_kind;
            r_last <= res_last;
            case (res_kind)
                KIND_HEADER: begin
                    r_hdr      <= hdr;
                    r_alen_out <= r_asdu_len;
                    r_pay      <= 8'd0;
                end
                KIND_PAYLOAD: begin
                    r_hdr      <= '0;
                    r_alen_out <= 16'd0;
                    r_pay      <= i_in_byte;
                end
                default: begin
                    r_hdr      <= '0;
                    r_alen_out <= 16'd0;
                    r_pay      <= 8'd0;
                end
            endcase
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_result_kind  = r_kind;
    assign o_apdu_format  = r_hdr.apdu_format;
    assign o_send_seq     = r_hdr.send_seq;
    assign o_recv_seq     = r_hdr.recv_seq;
    assign o_u_control    = r_hdr.u_control;
    assign o_asdu_length  = r_alen_out;
    assign o_apci_nonzero = r_hdr.apci_nonzero;
    assign o_payload_byte = r_pay;
    assign o_last         = r_last;

endmodule
`default_nettype wire

[bench/apci_frame_deframer_unit_test.sv]
// testbench for the apci frame deframer: predicted header, payload and reject words
module apci_frame_deframer_unit_test;
    import apcid_pkg::*;

    localparam int HOLD_CYCLES = 300;
    localparam int STALL_LIMIT = 5000;

    typedef struct packed {
        t_kind       kind;
        t_format     fmt;
        logic [14:0] send_seq;
        logic [14:0] recv_seq;
        logic [7:0]  u_control;
        logic [15:0] asdu_length;
        logic        apci_nonzero;
        logic [7:0]  payload_byte;
        logic        last;
    } deframe_word_t;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_we = 1'b0;
    logic [7:0]  i_cfg_data = START_BYTE_RESET;
    logic        i_in_valid = 1'b0;
    logic        o_in_stall;
    logic [7:0]  i_in_byte = 8'h00;
    logic        o_out_valid;
    logic        i_out_stall = 1'b0;
    logic [1:0]  o_result_kind;
    logic [1:0]  o_apdu_format;
    logic [14:0] o_send_seq;
    logic [14:0] o_recv_seq;
    logic [7:0]  o_u_control;
    logic [15:0] o_asdu_length;
    logic        o_apci_nonzero;
    logic [7:0]  o_payload_byte;
    logic        o_last;

    apci_frame_deframer_unit u_top (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_data     (i_cfg_data),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_in_byte      (i_in_byte),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_result_kind  (o_result_kind),
        .o_apdu_format  (o_apdu_format),
        .o_send_seq     (o_send_seq),
        .o_recv_seq     (o_recv_seq),
        .o_u_control    (o_u_control),
        .o_asdu_length  (o_asdu_length),
        .o_apci_nonzero (o_apci_nonzero),
        .o_payload_byte (o_payload_byte),
        .o_last         (o_last)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // predictor state
    t_phase      pr_phase = PH_HUNT;
    logic [15:0] pr_len = 16'h0000;
    logic [15:0] pr_count = 16'h0000;
    logic [7:0]  pr_apci [4] = '{8'h00, 8'h00, 8'h00, 8'h00};
    logic [7:0]  pr_start = START_BYTE_RESET;

    deframe_word_t expected_words[$];

    int fail_count = 0;
    int frame_items = 0;
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int hold_req = 0;
    int hold_seen = 0;
    int hold_left = 0;
    int quiet_cycles = 0;

    task automatic predict_byte(input logic [7:0] b);
        deframe_word_t w;
        w = '0;
        case (pr_phase)
            PH_LEN_LO: begin
                pr_len = {8'h00, b};
                pr_phase = PH_LEN_HI;
            end
            PH_LEN_HI: begin
                pr_len[15:8] = b;
                if (pr_len < APCI_BYTES) begin
                    w.kind = KIND_REJECT;
                    w.last = 1'b1;
                    expected_words.push_back(w);
                    pr_phase = PH_HUNT;
                end else begin
                    pr_count = 16'h0000;
                    pr_phase = PH_APCI;
                end
            end
            PH_APCI: begin
                pr_apci[pr_count[1:0]] = b;
                pr_count = pr_count + 16'd1;
                if (pr_count == APCI_BYTES) begin
                    w.kind = KIND_HEADER;
                    if (!pr_apci[0][0])
                        w.fmt = FMT_I;
                    else if (pr_apci[0] == S_FORMAT_CODE)
                        w.fmt = FMT_S;
                    else
                        w.fmt = FMT_U;
                    if (w.fmt == FMT_I)
                        w.send_seq = {pr_apci[1], pr_apci[0][7:1]};
                    if (w.fmt != FMT_U)
                        w.recv_seq = {pr_apci[3], pr_apci[2][7:1]};
                    w.u_control = pr_apci[0];
                    w.asdu_length = pr_len - APCI_BYTES;
                    w.apci_nonzero = |(pr_apci[0] | pr_apci[1] | pr_apci[2] | pr_apci[3]);
                    w.last = (w.asdu_length == 16'h0000);
                    expected_words.push_back(w);
                    pr_count = 16'h0000;
                    pr_phase = w.last ? PH_HUNT : PH_ASDU;
                end
            end
            PH_ASDU: begin
                pr_count = pr_count + 16'd1;
                w.kind = KIND_PAYLOAD;
                w.payload_byte = b;
                w.last = (pr_count >= pr_len - APCI_BYTES);
                expected_words.push_back(w);
                if (w.last)
                    pr_phase = PH_HUNT;
            end
            default: begin
                pr_phase = PH_HUNT;
                if (b == pr_start) begin
                    pr_len = 16'h0000;
                    pr_count = 16'h0000;
                    pr_phase = PH_LEN_LO;
                end
            end
        endcase
    endtask

    task automatic compare_field(input string name, input logic [15:0] exp_v,
                                 input logic [15:0] act_v);
        if (act_v !== exp_v) begin
            $error("%s: expected %0h, actual %0h", name, exp_v, act_v);
            fail_count++;
        end
    endtask

    task automatic check_word();
        deframe_word_t w;
        if (expected_words.size() == 0) begin
            $error("unexpected word: kind %0h", o_result_kind);
            fail_count++;
        end else begin
            w = expected_words.pop_front();
            compare_field("result_kind", 16'(w.kind), 16'(o_result_kind));
            compare_field("apdu_format", 16'(w.fmt), 16'(o_apdu_format));
            compare_field("send_seq", 16'(w.send_seq), 16'(o_send_seq));
            compare_field("recv_seq", 16'(w.recv_seq), 16'(o_recv_seq));
            compare_field("u_control", 16'(w.u_control), 16'(o_u_control));
            compare_field("asdu_length", w.asdu_length, o_asdu_length);
            compare_field("apci_nonzero", 16'(w.apci_nonzero), 16'(o_apci_nonzero));
            compare_field("payload_byte", 16'(w.payload_byte), 16'(o_payload_byte));
            compare_field("last", 16'(w.last), 16'(o_last));
        end
    endtask

    // output side: check each word, then pick the stall for the next cycle
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall)
            check_word();
        if (hold_seen != hold_req) begin
            hold_seen = hold_req;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left = hold_left - 1;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
        end
    end

    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall))
            quiet_cycles = 0;
        else
            quiet_cycles = quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    task automatic send_byte(input logic [7:0] b);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_byte <= b;
        @(posedge i_clk);
        while (o_in_stall)
            @(posedge i_clk);
        predict_byte(b);
    endtask

    task automatic drain();
        i_in_valid <= 1'b0;
        while (expected_words.size() != 0)
            @(posedge i_clk);
        repeat (3) @(posedge i_clk);
    endtask

    task automatic write_start_byte(input logic [7:0] v);
        drain();
        i_cfg_we <= 1'b1;
        i_cfg_data <= v;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        pr_start = v;
    endtask

    task automatic send_frame(input logic [15:0] len, input logic [7:0] a0, input logic [7:0] a1,
                              input logic [7:0] a2, input logic [7:0] a3, input int asdu_n);
        int k;
        send_byte(pr_start);
        send_byte(len[7:0]);
        send_byte(len[15:8]);
        frame_items += 3;
        if (len >= APCI_BYTES) begin
            send_byte(a0);
            send_byte(a1);
            send_byte(a2);
            send_byte(a3);
            for (k = 0; k < asdu_n; k++)
                send_byte(8'($urandom_range(0, 255)));
            frame_items += 4 + asdu_n;
        end
    endtask

    task automatic random_apci(output logic [7:0] a0, output logic [7:0] a1,
                               output logic [7:0] a2, output logic [7:0] a3);
        a0 = 8'($urandom_range(0, 255));
        a1 = 8'($urandom_range(0, 255));
        a2 = 8'($urandom_range(0, 255));
        a3 = 8'($urandom_range(0, 255));
        case ($urandom_range(0, 4))
            0: a0 = a0 & 8'hFE;
            1: begin
                a0 = S_FORMAT_CODE;
                a1 = 8'h00;
            end
            2: a0 = 8'(($urandom_range(1, 127) << 1) | 1);
            3: begin
                a0 = 8'h00;
                a1 = 8'h00;
                a2 = 8'h00;
                a3 = 8'h00;
            end
            default: ;
        endcase
    endtask

    task automatic send_random_frame();
        logic [7:0]  a0, a1, a2, a3;
        logic [15:0] len;
        int          sel, asdu_n, k;
        sel = $urandom_range(0, 99);
        if (sel < 10)
            len = 16'($urandom_range(0, 3));
        else if (sel < 75)
            len = 16'($urandom_range(4, 24));
        else if (sel < 95)
            len = 16'($urandom_range(25, 80));
        else
            len = 16'($urandom_range(256, 320));
        random_apci(a0, a1, a2, a3);
        asdu_n = (len >= APCI_BYTES) ? int'(len) - 4 : 0;
        // broken frame: cut short, the next bytes land in its payload
        if (asdu_n > 0 && $urandom_range(0, 99) < 8)
            asdu_n = $urandom_range(0, asdu_n - 1);
        if ($urandom_range(0, 99) < 15) begin
            for (k = $urandom_range(1, 4); k > 0; k--)
                send_byte(8'($urandom_range(0, 255)));
        end
        send_frame(len, a0, a1, a2, a3, asdu_n);
    endtask

    task automatic test_directed_frames();
        send_idle_pct = 13;
        recv_idle_pct = 45;
        send_byte(8'h00);
        send_byte(8'hFF);
        send_byte(8'h67);
        send_frame(16'd4, 8'h00, 8'h00, 8'h00, 8'h00, 0);
        send_frame(16'd3, 8'h00, 8'h00, 8'h00, 8'h00, 0);
        send_frame(16'd0, 8'h00, 8'h00, 8'h00, 8'h00, 0);
        send_frame(16'd6, 8'hFE, 8'hFF, 8'hFE, 8'hFF, 2);
        send_frame(16'd4, S_FORMAT_CODE, 8'h00, 8'hFE, 8'hFF, 0);
        send_frame(16'd5, 8'h43, 8'h00, 8'h00, 8'h00, 1);
        send_frame(16'd4, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 0);
        send_byte(8'h12);
        send_frame(16'd7, 8'h02, 8'h00, 8'h04, 8'h00, 3);
    endtask

    task automatic test_start_byte_extremes();
        write_start_byte(8'h00);
        send_byte(8'hFF);
        send_frame(16'd5, 8'h0B, 8'h00, 8'h00, 8'h00, 1);
        send_frame(16'd2, 8'h00, 8'h00, 8'h00, 8'h00, 0);
        write_start_byte(8'hFF);
        send_byte(8'h00);
        send_byte(8'h68);
        send_frame(16'd6, 8'h10, 8'h20, 8'h30, 8'h40, 2);
        write_start_byte(START_BYTE_RESET);
        send_frame(16'd4, 8'h00, 8'h80, 8'h00, 8'h80, 0);
    endtask

    task automatic test_random_frames(input int snd_pct, input int rcv_pct,
                                      input logic [7:0] start, input int n_items);
        int target;
        send_idle_pct = snd_pct;
        recv_idle_pct = rcv_pct;
        write_start_byte(start);
        target = frame_items + n_items;
        while (frame_items < target)
            send_random_frame();
    endtask

    task automatic test_receiver_hold_off();
        int saved_pct;
        saved_pct = send_idle_pct;
        drain();
        send_idle_pct = 0;
        hold_req <= hold_req + 1;
        repeat (4) send_random_frame();
        send_idle_pct = saved_pct;
    endtask

    task automatic test_pause_until_drained();
        send_random_frame();
        drain();
        send_random_frame();
        drain();
        send_frame(16'd9, 8'h22, 8'h11, 8'h44, 8'h33, 5);
    endtask

    // largest length field; the frame stays open after its first payload words
    task automatic test_longest_frame();
        logic [7:0] a0, a1, a2, a3;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        random_apci(a0, a1, a2, a3);
        send_frame(16'hFFFF, a0, a1, a2, a3, 6);
    endtask

    initial begin
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed_frames();
        test_start_byte_extremes();
        test_random_frames(13, 45, 8'($urandom_range(0, 255)), 350);
        test_receiver_hold_off();
        test_random_frames(45, 13, 8'hFF, 350);
        test_random_frames(0, 0, START_BYTE_RESET, 350);
        test_pause_until_drained();
        test_longest_frame();
        drain();
        repeat (5) @(posedge i_clk);
        if (fail_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

[apci_frame_deframer_unit.f]
src/apcid_pkg.sv
src/apcid_header_decode.sv
src/apci_frame_deframer_unit.sv
bench/apci_frame_deframer_unit_test.sv
